@@ sv/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Shared widths, command codes and controller/datapath handoff types for the
// scalar tracker.
// ----------------------------------------------------------------------------
package skt_pkg;

    // Data word width (signed Q16.16), full product width, divider step counter width
    localparam int DW = 32;
    localparam int PW = 2 * DW;
    localparam int CW = $clog2(DW);

    // Command codes carried by an input word
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_UPDATE  = 2'd1;
    localparam logic [1:0] CMD_PREDICT = 2'd2;

    // Operand pairs for the shared multiplier
    typedef enum logic [1:0] {
        MUL_GROW,   // process noise times elapsed ticks
        MUL_CORR,   // grown variance times |z - x|
        MUL_VAR     // measurement noise times grown variance
    } t_mul_sel;

    // How the state is written back at the end of an update
    typedef enum logic [1:0] {
        CM_FIRST,   // first measurement: take z and r as they are
        CM_ZERO,    // zero weight sum: keep x, clear p
        CM_BLEND    // regular blend from the two quotients
    } t_commit_mode;

    typedef struct packed {
        logic         latch;
        logic         tick;
        logic         mul_en;
        t_mul_sel     mul_sel;
        logic         grow;
        logic         prep;
        logic         div_load;
        logic         div_step;
        logic         save_corr;
        logic         commit;
        t_commit_mode commit_mode;
        logic         emit;
        logic         emit_pred;
    } t_dp_cmd;

    typedef struct packed {
        logic started;
        logic den_zero;
        logic out_free;
    } t_dp_stat;

endpackage

@@ sv/skt_if.sv @@
// ----------------------------------------------------------------------------
// skt_in_if / skt_out_if
// Valid/ready channels for the tracker: command words in, result words out.
// ----------------------------------------------------------------------------
interface skt_in_if
    import skt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic signed [DW-1:0] measurement;
    logic [DW-1:0]        measurement_noise;

    modport source (output valid, command, measurement, measurement_noise, input ready);
    modport sink   (input valid, command, measurement, measurement_noise, output ready);
endinterface

interface skt_out_if
    import skt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] estimate;
    logic [DW-1:0]        variance;
    logic                 initialized;

    modport source (output valid, estimate, variance, initialized, input ready);
    modport sink   (input valid, estimate, variance, initialized, output ready);
endinterface

@@ sv/skt_datapath.sv @@
// ----------------------------------------------------------------------------
// skt_datapath
// Tracker state, shared multiplier, restoring divider and output register.
// ----------------------------------------------------------------------------
module skt_datapath
    import skt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [DW-1:0]        i_cfg_wr_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic signed [DW-1:0] i_measurement,
    input  logic [DW-1:0]        i_measurement_noise,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [DW-1:0] o_estimate,
    output logic [DW-1:0]        o_variance,
    output logic                 o_initialized
);

    // State and config
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_p;
    logic [DW-1:0] r_elapsed;
    logic          r_started;

    // Work registers
    logic [DW-1:0] r_z;
    logic [DW-1:0] r_r;
    logic [DW-1:0] r_pg;
    logic [DW-1:0] r_mag;
    logic          r_neg;
    logic [DW:0]   r_den;
    logic [PW-1:0] r_prod;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_num;
    logic [DW-1:0] r_quot;
    logic [DW-1:0] r_corr;

    // Output register
    logic          r_o_valid;
    logic [DW-1:0] r_o_est;
    logic [DW-1:0] r_o_var;
    logic          r_o_init;

    logic [DW-1:0] mul_a;
    logic [DW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic [DW:0]   grow_sum;
    logic [DW-1:0] grow_val;
    logic [DW:0]   den_sum;
    logic [DW:0]   diff;
    logic [DW:0]   diff_abs;
    logic [DW+1:0] trial;
    logic [DW+1:0] trial_sub;
    logic          div_ge;
    logic [DW-1:0] blend_x;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_CORR: begin
                mul_a = r_pg;
                mul_b = r_mag;
            end
            MUL_VAR: begin
                mul_a = r_r;
                mul_b = r_pg;
            end
            default: begin
                mul_a = r_q;
                mul_b = r_elapsed;
            end
        endcase
    end

    assign mul_p = {{DW{1'b0}}, mul_a} * {{DW{1'b0}}, mul_b};

    // Saturate the growth product, then the sum with p
    assign grow_sum = {1'b0, r_prod[DW-1:0]} + {1'b0, r_p};
    assign grow_val = ((|r_prod[PW-1:DW]) || grow_sum[DW]) ? '1 : grow_sum[DW-1:0];

    assign den_sum  = {1'b0, r_r} + {1'b0, r_pg};
    assign diff     = {r_z[DW-1], r_z} - {r_x[DW-1], r_x};
    assign diff_abs = diff[DW] ? (~diff + 1'b1) : diff;

    // One quotient bit per step; the remainder always stays below den
    assign trial     = {r_rem, r_num[DW-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign div_ge    = (trial >= {1'b0, r_den});

    assign blend_x = r_neg ? (r_x - r_corr) : (r_x + r_corr);

    assign o_stat.started  = r_started;
    assign o_stat.den_zero = (r_r == '0) && (r_pg == '0);
    assign o_stat.out_free = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q       <= '0;
            r_x       <= '0;
            r_p       <= '0;
            r_elapsed <= '0;
            r_started <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_q <= i_cfg_wr_data;
            end
            if (i_cmd.tick && (r_elapsed != '1)) begin
                r_elapsed <= r_elapsed + 1'b1;
            end
            if (i_cmd.commit) begin
                r_elapsed <= '0;
                unique case (i_cmd.commit_mode)
                    CM_FIRST: begin
                        r_x       <= r_z;
                        r_p       <= r_r;
                        r_started <= 1'b1;
                    end
                    CM_ZERO: begin
                        r_p <= '0;
                    end
                    default: begin
                        r_x <= blend_x;
                        r_p <= r_quot;
                    end
                endcase
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_z <= i_measurement;
            r_r <= i_measurement_noise;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.grow) begin
            r_pg <= grow_val;
        end
        if (i_cmd.prep) begin
            r_den <= den_sum;
            r_neg <= diff[DW];
            r_mag <= diff_abs[DW-1:0];
        end
        if (i_cmd.div_load) begin
            r_rem  <= {1'b0, r_prod[PW-1:DW]};
            r_num  <= r_prod[DW-1:0];
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= div_ge ? trial_sub[DW:0] : trial[DW:0];
            r_num  <= {r_num[DW-2:0], 1'b0};
            r_quot <= {r_quot[DW-2:0], div_ge};
        end
        if (i_cmd.save_corr) begin
            r_corr <= r_quot;
        end
        if (i_cmd.emit) begin
            if (i_cmd.emit_pred) begin
                r_o_est  <= r_started ? r_x : '0;
                r_o_var  <= r_started ? r_pg : '0;
                r_o_init <= r_started;
            end else begin
                r_o_est  <= r_x;
                r_o_var  <= r_p;
                r_o_init <= 1'b1;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_estimate    = r_o_est;
    assign o_variance    = r_o_var;
    assign o_initialized = r_o_init;

endmodule

@@ sv/skt_ctrl.sv @@
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer for the tracker: decodes each command word and steps the
// datapath through growth, blend products and the two divisions.
// ----------------------------------------------------------------------------
module skt_ctrl
    import skt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_command,
    output logic       o_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GROW_MUL,
        S_GROW_ADD,
        S_PREP,
        S_MUL_A,
        S_LOAD_A,
        S_DIV_A,
        S_MUL_B,
        S_LOAD_B,
        S_DIV_B,
        S_COMMIT,
        S_EMIT
    } t_state;

    t_state       r_state;
    logic [CW-1:0] r_cnt;
    logic         r_pred;
    t_commit_mode r_mode;
    logic         accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pred  <= 1'b0;
            r_mode  <= CM_FIRST;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode <= CM_FIRST;
                        if (i_command == CMD_UPDATE) begin
                            r_pred  <= 1'b0;
                            r_state <= i_stat.started ? S_GROW_MUL : S_COMMIT;
                        end else if (i_command == CMD_PREDICT) begin
                            r_pred  <= 1'b1;
                            r_state <= i_stat.started ? S_GROW_MUL : S_EMIT;
                        end
                    end
                end
                S_GROW_MUL: r_state <= S_GROW_ADD;
                S_GROW_ADD: r_state <= r_pred ? S_EMIT : S_PREP;
                S_PREP: begin
                    if (i_stat.den_zero) begin
                        r_mode  <= CM_ZERO;
                        r_state <= S_COMMIT;
                    end else begin
                        r_mode  <= CM_BLEND;
                        r_state <= S_MUL_A;
                    end
                end
                S_MUL_A: r_state <= S_LOAD_A;
                S_LOAD_A: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV_A;
                end
                S_DIV_A: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DW - 1)) begin
                        r_state <= S_MUL_B;
                    end
                end
                S_MUL_B: r_state <= S_LOAD_B;
                S_LOAD_B: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV_B;
                end
                S_DIV_B: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DW - 1)) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.mul_sel     = MUL_GROW;
        o_cmd.commit_mode = r_mode;
        o_cmd.emit_pred   = r_pred;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = accept;
                o_cmd.tick  = accept && (i_command == CMD_TICK);
            end
            S_GROW_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GROW;
            end
            S_GROW_ADD: o_cmd.grow = 1'b1;
            S_PREP:     o_cmd.prep = 1'b1;
            S_MUL_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_CORR;
            end
            S_LOAD_A:   o_cmd.div_load = 1'b1;
            S_DIV_A:    o_cmd.div_step = 1'b1;
            S_MUL_B: begin
                o_cmd.save_corr = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MUL_VAR;
            end
            S_LOAD_B:   o_cmd.div_load = 1'b1;
            S_DIV_B:    o_cmd.div_step = 1'b1;
            S_COMMIT:   o_cmd.commit = 1'b1;
            S_EMIT:     o_cmd.emit = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

@@ sv/scalar_kalman_tracker.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_tracker
// One-dimensional Kalman-style tracker in signed Q16.16 with a shared
// multiplier and a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
// The block takes one command word at a time. A tick word bumps a saturating
// elapsed-tick counter; it yields no result. A predict word yields the
// estimate and the variance grown by process_noise_per_tick times the elapsed
// ticks, through one multiply, one saturating add and one output load; before
// the first update it yields all-zero fields. An update word blends the
// measurement into the estimate; once the filter has started it runs the
// growth multiply and add, the weight sum, two products on the shared 32x32
// multiplier and two 32-step restoring divisions on the same divider, one
// quotient bit per cycle, then the write-back. The very first update and an
// update whose weight sum is zero skip the blend products and the divisions.
// Each update and predict word gives exactly one result word, held in an
// output register; the input side stays busy until that register has room
// for the new result. process_noise_per_tick must be written through the
// configuration port only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module scalar_kalman_tracker
    import skt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [DW-1:0] i_cfg_wr_data,
    skt_in_if.sink        i_in,
    skt_out_if.source     o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer: owns the input handshake and the step order
    skt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_command (i_in.command),
        .o_ready   (i_in.ready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    // Datapath: state, arithmetic and the result register
    skt_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .i_measurement       (i_in.measurement),
        .i_measurement_noise (i_in.measurement_noise),
        .o_valid             (o_out.valid),
        .i_ready             (o_out.ready),
        .o_estimate          (o_out.estimate),
        .o_variance          (o_out.variance),
        .o_initialized       (o_out.initialized)
    );

    // A tick word never leaves the sequencer busy
    a_tick_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.command == CMD_TICK)) |=> i_in.ready)
        else $error("tick word left the sequencer busy");

    // A result word appears only after the sequencer has left idle
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result word raised while sequencer was idle");

    // An uninitialized result carries zero fields
    a_uninit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.initialized) |->
            ((o_out.estimate == '0) && (o_out.variance == '0)))
        else $error("uninitialized result word carries nonzero fields");

endmodule
